FILE: rtl/ftsl_pkg.sv
package ftsl_pkg;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_HORIZ = 2'd1,
        MODE_VERT  = 2'd2
    } filter_mode_t;

    // register index, taken from paddr[2]
    localparam logic REG_FILTER_MODE = 1'b0;
    localparam logic REG_PHASE       = 1'b1;

    localparam int ROUND_SHIFT = 5;
    localparam int SUM_W       = 16;
    localparam int COL_W       = 7;
    localparam logic [COL_W-1:0] COL_MAX = 7'd127;
    localparam logic [1:0]       ROW_FULL = 2'd3;

    typedef logic signed [5:0] coef_t;

    // coefficient of one tap for one phase; tap 0 is the oldest sample
    function automatic coef_t coef(input logic [1:0] phase, input logic [1:0] tap);
        coef_t c;
        c = 6'sd0;
        case (phase)
            2'd1:
            begin
                case (tap)
                    2'd1:    c = 6'sd25;
                    2'd2:    c = 6'sd9;
                    default: c = -6'sd1;
                endcase
            end
            2'd2:
            begin
                case (tap)
                    2'd1:    c = 6'sd18;
                    2'd2:    c = 6'sd18;
                    default: c = -6'sd2;
                endcase
            end
            2'd3:
            begin
                case (tap)
                    2'd1:    c = 6'sd9;
                    2'd2:    c = 6'sd25;
                    default: c = -6'sd1;
                endcase
            end
            default: c = 6'sd0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/ftsl_taps.sv
module ftsl_taps (
    input  logic [1:0] phase,
    input  logic [7:0] p0,
    input  logic [7:0] p1,
    input  logic [7:0] p2,
    input  logic [7:0] p3,
    output logic [7:0] pixel
);

    logic signed [ftsl_pkg::SUM_W-1:0] prod0;
    logic signed [ftsl_pkg::SUM_W-1:0] prod1;
    logic signed [ftsl_pkg::SUM_W-1:0] prod2;
    logic signed [ftsl_pkg::SUM_W-1:0] prod3;
    logic signed [ftsl_pkg::SUM_W-1:0] sum;
    logic signed [ftsl_pkg::SUM_W-1:0] shifted;

    always_comb
    begin
        prod0 = ftsl_pkg::SUM_W'(ftsl_pkg::coef(phase, 2'd0)) * $signed({8'd0, p0});
        prod1 = ftsl_pkg::SUM_W'(ftsl_pkg::coef(phase, 2'd1)) * $signed({8'd0, p1});
        prod2 = ftsl_pkg::SUM_W'(ftsl_pkg::coef(phase, 2'd2)) * $signed({8'd0, p2});
        prod3 = ftsl_pkg::SUM_W'(ftsl_pkg::coef(phase, 2'd3)) * $signed({8'd0, p3});
        sum = prod0 + prod1 + prod2 + prod3
            + ftsl_pkg::SUM_W'(1 << (ftsl_pkg::ROUND_SHIFT - 1));
        shifted = sum >>> ftsl_pkg::ROUND_SHIFT;
        // clip to the sample range
        if (sum < 0)
        begin
            pixel = 8'd0;
        end
        else if (shifted > 16'sd255)
        begin
            pixel = 8'd255;
        end
        else
        begin
            pixel = shifted[7:0];
        end
    end

endmodule

FILE: rtl/four_tap_subpel_luma_filter.sv
// Four-tap sub-pixel luma filter, copy / horizontal / vertical.
// Output path: the input transfer loads the first-stage registers, then the result register
// loads when the output is free (no valid output held, or m_tready), and drives the output stream.
// Throughput: one sample per cycle unless the output stalls; the line-store memory takes one read at
// input transfer and one write as the item leaves the first stage, with a bypass for the same column.
// Reset (rst_n, asynchronous, active low) clears config, taps, counters and valids.
module four_tap_subpel_luma_filter #(
    parameter int MAX_ROW_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tlast,   // row_end
    input  logic        s_tuser,   // [0] block_start
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel
    output logic        m_tlast    // row_last
);

    localparam int ADDR_W = (MAX_ROW_SAMPLES > 1) ? $clog2(MAX_ROW_SAMPLES) : 1;
    localparam logic [ftsl_pkg::COL_W:0] COL_LIMIT = (ftsl_pkg::COL_W + 1)'(MAX_ROW_SAMPLES);
    localparam logic [ftsl_pkg::COL_W:0] COL_LAST  = (ftsl_pkg::COL_W + 1)'(MAX_ROW_SAMPLES - 1);

    // configuration
    logic [1:0] filter_mode_reg;
    logic [1:0] phase_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= 2'd0;
            phase_reg       <= 2'd0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ftsl_pkg::REG_FILTER_MODE)
            begin
                filter_mode_reg <= pwdata[1:0];
            end
            else
            begin
                phase_reg <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == ftsl_pkg::REG_FILTER_MODE) ? {30'd0, filter_mode_reg}
                                                            : {30'd0, phase_reg};

    // counters and taps, advanced on each input transfer
    logic [ftsl_pkg::COL_W-1:0] column_count_reg;
    logic [1:0]                 row_count_reg;
    logic [7:0]                 tap_reg [3];
    logic [ftsl_pkg::COL_W-1:0] col_eff;
    logic [1:0]                 row_eff;
    logic [ftsl_pkg::COL_W:0]   col_clamp;
    logic [ADDR_W-1:0]          addr_now;
    logic [ftsl_pkg::COL_W-1:0] column_count_next;
    logic [1:0]                 row_count_next;
    logic                       s_accept;

    always_comb
    begin
        col_eff = s_tuser ? '0 : column_count_reg;
        row_eff = s_tuser ? 2'd0 : row_count_reg;
        // long rows share the last slot
        col_clamp = ({1'b0, col_eff} >= COL_LIMIT) ? COL_LAST : {1'b0, col_eff};
        addr_now  = col_clamp[ADDR_W-1:0];
        if (s_tlast)
        begin
            column_count_next = '0;
            row_count_next    = (row_eff == ftsl_pkg::ROW_FULL) ? row_eff : row_eff + 2'd1;
        end
        else
        begin
            column_count_next = (col_eff == ftsl_pkg::COL_MAX) ? col_eff : col_eff + 1'b1;
            row_count_next    = row_eff;
        end
    end

    // first stage
    logic              s1_valid_reg;
    logic [7:0]        s1_sample_reg;
    logic              s1_last_reg;
    logic              s1_horiz_ok_reg;
    logic              s1_vert_ok_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_tap_reg [3];
    logic              s1_produce;
    logic              s1_advance;

    // output stage
    logic       out_valid_reg;
    logic [7:0] out_pixel_reg;
    logic       out_last_reg;
    logic       out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && (!s1_produce || out_free);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_comb
    begin
        case (filter_mode_reg)
            ftsl_pkg::MODE_HORIZ: s1_produce = s1_horiz_ok_reg;
            ftsl_pkg::MODE_VERT:  s1_produce = s1_vert_ok_reg;
            default:              s1_produce = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= 2'd0;
            tap_reg[0]       <= 8'd0;
            tap_reg[1]       <= 8'd0;
            tap_reg[2]       <= 8'd0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                tap_reg[0]       <= tap_reg[1];
                tap_reg[1]       <= tap_reg[2];
                tap_reg[2]       <= s_tdata;
            end
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // line store: one word per column holding the three rows, oldest lowest
    logic [23:0] line_mem [MAX_ROW_SAMPLES];
    logic [23:0] rd_data_reg;
    logic [23:0] byp_data_reg;
    logic        byp_sel_reg;
    logic [23:0] s1_entry;
    logic [23:0] s1_entry_next;

    assign s1_entry      = byp_sel_reg ? byp_data_reg : rd_data_reg;
    assign s1_entry_next = {s1_sample_reg, s1_entry[23:16], s1_entry[15:8]};

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            line_mem[s1_addr_reg] <= s1_entry_next;
        end
        if (s_accept)
        begin
            rd_data_reg <= line_mem[addr_now];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            // forward the word being written when the new item reads the same column
            byp_sel_reg     <= s1_advance && (s1_addr_reg == addr_now);
            byp_data_reg    <= s1_entry_next;
            s1_sample_reg   <= s_tdata;
            s1_last_reg     <= s_tlast;
            s1_horiz_ok_reg <= (col_eff >= 7'd3);
            s1_vert_ok_reg  <= (row_eff == ftsl_pkg::ROW_FULL);
            s1_addr_reg     <= addr_now;
            s1_tap_reg[0]   <= tap_reg[0];
            s1_tap_reg[1]   <= tap_reg[1];
            s1_tap_reg[2]   <= tap_reg[2];
        end
    end

    // filter datapath
    logic [7:0] f_p0;
    logic [7:0] f_p1;
    logic [7:0] f_p2;
    logic [7:0] f_pixel;
    logic [7:0] result_pixel;

    always_comb
    begin
        if (filter_mode_reg == ftsl_pkg::MODE_VERT)
        begin
            f_p0 = s1_entry[7:0];
            f_p1 = s1_entry[15:8];
            f_p2 = s1_entry[23:16];
        end
        else
        begin
            f_p0 = s1_tap_reg[0];
            f_p1 = s1_tap_reg[1];
            f_p2 = s1_tap_reg[2];
        end
    end

    ftsl_taps u_taps (
        .phase (phase_reg),
        .p0    (f_p0),
        .p1    (f_p1),
        .p2    (f_p2),
        .p3    (s1_sample_reg),
        .pixel (f_pixel)
    );

    always_comb
    begin
        case (filter_mode_reg)
            ftsl_pkg::MODE_HORIZ: result_pixel = f_pixel;
            ftsl_pkg::MODE_VERT:  result_pixel = f_pixel;
            default:              result_pixel = s1_sample_reg;
        endcase
    end

    // hold the result until the downstream transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_produce)
        begin
            out_pixel_reg <= result_pixel;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: dv/ftsl_checker.sv
`timescale 1ns / 100ps

module ftsl_checker #(
    parameter int MAX_ROW_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tlast,   // row_end
    input  logic        s_tuser,   // [0] block_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] pixel
    input  logic        m_tlast,   // row_last
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_last;
    } subpel_t;

    subpel_t                    pixel_queue[$];
    subpel_t                    head_pix;
    logic [1:0]                 mode_q;
    logic [1:0]                 phase_q;
    logic [7:0]                 tap_hist[3];
    logic [7:0]                 line_mem[3*MAX_ROW_SAMPLES];
    logic [ftsl_pkg::COL_W-1:0] col_cnt;
    logic [1:0]                 row_cnt;

    // p0 is the oldest sample, p3 the newest
    function automatic logic [7:0] interp_pixel(input logic [1:0] ph,
                                                input logic [7:0] p0, input logic [7:0] p1,
                                                input logic [7:0] p2, input logic [7:0] p3);
        int acc;
        case (ph)
            2'd1:    acc = -int'(p0) + 25 * int'(p1) + 9 * int'(p2) - int'(p3);
            2'd2:    acc = -2 * int'(p0) + 18 * int'(p1) + 18 * int'(p2) - 2 * int'(p3);
            2'd3:    acc = -int'(p0) + 9 * int'(p1) + 25 * int'(p2) - int'(p3);
            default: acc = 0;
        endcase
        acc = acc + (1 << (ftsl_pkg::ROUND_SHIFT - 1));
        if (acc < 0)
            return 8'd0;
        acc = acc >>> ftsl_pkg::ROUND_SHIFT;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic predict_step(input logic [7:0] smp, input logic blk_start,
                                input logic row_end);
        int      col;
        subpel_t want;
        bit      produces;
        if (blk_start)
        begin
            col_cnt = '0;
            row_cnt = '0;
        end
        col = (col_cnt >= MAX_ROW_SAMPLES) ? MAX_ROW_SAMPLES - 1 : int'(col_cnt);
        produces = 1'b1;
        want.row_last = row_end;
        if (mode_q == ftsl_pkg::MODE_HORIZ)
        begin
            produces = (col_cnt >= 3);
            want.pixel = interp_pixel(phase_q, tap_hist[0], tap_hist[1], tap_hist[2], smp);
        end
        else if (mode_q == ftsl_pkg::MODE_VERT)
        begin
            produces = (row_cnt == ftsl_pkg::ROW_FULL);
            want.pixel = interp_pixel(phase_q, line_mem[col], line_mem[MAX_ROW_SAMPLES + col],
                                      line_mem[2*MAX_ROW_SAMPLES + col], smp);
        end
        else
        begin
            want.pixel = smp;
        end
        if (produces)
            pixel_queue.push_back(want);

        // advance history every transfer, whatever the mode
        tap_hist[0] = tap_hist[1];
        tap_hist[1] = tap_hist[2];
        tap_hist[2] = smp;
        line_mem[col] = line_mem[MAX_ROW_SAMPLES + col];
        line_mem[MAX_ROW_SAMPLES + col] = line_mem[2*MAX_ROW_SAMPLES + col];
        line_mem[2*MAX_ROW_SAMPLES + col] = smp;

        if (row_end)
        begin
            col_cnt = '0;
            if (row_cnt != ftsl_pkg::ROW_FULL)
                row_cnt = row_cnt + 2'd1;
        end
        else if (col_cnt != ftsl_pkg::COL_MAX)
        begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode_q = ftsl_pkg::MODE_COPY;
            phase_q = 2'd0;
            tap_hist = '{3{8'd0}};
            col_cnt = '0;
            row_cnt = '0;
            mismatches = 0;
            pixel_queue.delete();
        end
        else
        begin
            // compare first: a transfer in at this edge cannot come out at the same edge
            if (m_tvalid && m_tready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output pixel %0d row_last %0b", m_tdata, m_tlast);
                end
                else
                begin
                    head_pix = pixel_queue.pop_front();
                    if (head_pix.pixel !== m_tdata || head_pix.row_last !== m_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: expected %0d row_last %0b, got %0d row_last %0b",
                                     head_pix.pixel, head_pix.row_last, m_tdata, m_tlast);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == ftsl_pkg::REG_PHASE)
                    phase_q = pwdata[1:0];
                else
                    mode_q = pwdata[1:0];
            end
            if (s_tvalid && s_tready)
                predict_step(s_tdata, s_tuser, s_tlast);
        end
        outstanding <= pixel_queue.size();
    end

endmodule

FILE: dv/tb_four_tap_subpel_luma_filter.sv
`timescale 1ns / 100ps

module tb_four_tap_subpel_luma_filter;

    localparam int ROW_SLOTS      = 64;
    localparam int RANDOM_ITEMS   = 380;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] sample
    logic        s_tlast;   // row_end
    logic        s_tuser;   // [0] block_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] pixel
    logic        m_tlast;   // row_last

    int mismatches;
    int outstanding;
    int sent_items = 0;
    int quiet_cycles = 0;
    bit stall_en = 1'b1;

    four_tap_subpel_luma_filter #(
        .MAX_ROW_SAMPLES(ROW_SLOTS)
    ) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    ftsl_checker #(
        .MAX_ROW_SAMPLES(ROW_SLOTS)
    ) u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= !stall_en || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // hold the transfer until accepted; valid stays high for a following call
    task automatic push_sample(input logic [7:0] smp, input logic blk_start,
                               input logic row_end);
        while (stall_en && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= blk_start;
        s_tlast  <= row_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    // drain the pipeline: rows can end with a result still in flight
    task automatic drain_results();
        s_tvalid <= 1'b0;
        repeat (3) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {30'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_block(input int rows, input int width, input bit noisy);
        logic blk_start;
        logic row_end;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < width; c++)
            begin
                blk_start = (r == 0 && c == 0);
                row_end = (c == width - 1);
                if (noisy && $urandom_range(99) < 6)
                    blk_start = ~blk_start;
                if (noisy && $urandom_range(99) < 6)
                    row_end = ~row_end;
                push_sample(pick_sample(), blk_start, row_end);
            end
        end
    endtask

    initial
    begin
        int                     target;
        int                     phase_no;
        int                     width;
        ftsl_pkg::filter_mode_t next_mode;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // copy mode straight out of reset
        push_sample(8'd0, 1'b1, 1'b0);
        push_sample(8'd255, 1'b0, 1'b0);
        push_sample(8'hAA, 1'b0, 1'b0);
        push_sample(8'h55, 1'b0, 1'b1);

        // unused mode code falls back to copy
        drain_results();
        reg_write(ftsl_pkg::REG_FILTER_MODE, 2'd3);
        push_sample(8'h0F, 1'b1, 1'b0);
        push_sample(8'hF0, 1'b0, 1'b1);

        // fill every line-store slot with three rows so vertical reads never see unwritten entries
        drain_results();
        reg_write(ftsl_pkg::REG_FILTER_MODE, ftsl_pkg::MODE_COPY);
        send_block(3, ROW_SLOTS, 1'b0);

        // horizontal: negative sum clips to zero, large sum clips to 255
        drain_results();
        reg_write(ftsl_pkg::REG_FILTER_MODE, ftsl_pkg::MODE_HORIZ);
        reg_write(ftsl_pkg::REG_PHASE, 2'd1);
        push_sample(8'd255, 1'b1, 1'b0);
        push_sample(8'd0, 1'b0, 1'b0);
        push_sample(8'd0, 1'b0, 1'b0);
        push_sample(8'd255, 1'b0, 1'b0);
        push_sample(8'd255, 1'b0, 1'b0);
        push_sample(8'd255, 1'b0, 1'b0);
        push_sample(8'd0, 1'b0, 1'b1);

        // phase zero in a filter mode gives zero
        drain_results();
        reg_write(ftsl_pkg::REG_PHASE, 2'd0);
        push_sample(8'd200, 1'b0, 1'b0);
        push_sample(8'd100, 1'b0, 1'b0);
        push_sample(8'd50, 1'b0, 1'b0);
        push_sample(8'd25, 1'b0, 1'b0);
        push_sample(8'd12, 1'b0, 1'b1);

        // vertical: nothing until three rows are in
        drain_results();
        reg_write(ftsl_pkg::REG_FILTER_MODE, ftsl_pkg::MODE_VERT);
        reg_write(ftsl_pkg::REG_PHASE, 2'd3);
        send_block(4, 3, 1'b0);

        target = sent_items + RANDOM_ITEMS;
        phase_no = 0;
        while (sent_items < target)
        begin
            drain_results();
            case (phase_no % 3)
                0:       next_mode = ftsl_pkg::MODE_COPY;
                1:       next_mode = ftsl_pkg::MODE_HORIZ;
                default: next_mode = ftsl_pkg::MODE_VERT;
            endcase
            reg_write(ftsl_pkg::REG_FILTER_MODE, next_mode);
            reg_write(ftsl_pkg::REG_PHASE, 2'(phase_no % 4));
            stall_en = (phase_no % 5 != 2);
            for (int blk = 0; blk < 3; blk++)
            begin
                // one very long row to saturate the column counter
                if (phase_no == 1 && blk == 0)
                    width = 135;
                else if ($urandom_range(14) == 0)
                    width = $urandom_range(60, 135);
                else
                    width = $urandom_range(1, 10);
                // long rows go one at a time
                send_block((width > 10) ? 1 : $urandom_range(1, 6), width,
                           $urandom_range(3) == 0);
            end
            phase_no++;
        end

        stall_en = 1'b1;
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ftsl_pkg.sv
rtl/ftsl_taps.sv
rtl/four_tap_subpel_luma_filter.sv
dv/ftsl_checker.sv
dv/tb_four_tap_subpel_luma_filter.sv
